>>> rtl/uct_score_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the UCT score unit.
// ----------------------------------------------------------------------------
`ifndef UCT_SCORE_UNIT_ASSERT_SVH
`define UCT_SCORE_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define UCT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define UCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/uct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uct_pkg
// Widths, constants and pipeline stage map of the UCT score unit.
// ----------------------------------------------------------------------------
package uct_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int FRAC_BITS   = 16;
  localparam int SCORE_W     = 21;
  localparam int C_W         = 16;
  localparam int C_FRAC      = 14;
  localparam logic [C_W-1:0] C_RESET = 16'd23170;
  localparam int MANT_FRAC   = 30;
  localparam int Y_W         = MANT_FRAC + 1;
  localparam int K_W         = $clog2(COUNT_WIDTH);
  localparam int L2_W        = K_W + FRAC_BITS;
  localparam int LN2_W       = 32;
  localparam logic [LN2_W-1:0] LN2_Q32 = 32'd2977044472;
  localparam int LN_W        = L2_W;
  localparam int P_W         = FRAC_BITS + 1;
  localparam int R_W         = LN_W;
  localparam int SX_W        = R_W + FRAC_BITS;
  localparam int S_W         = (SX_W + 1) / 2;
  localparam int SRES_W      = SX_W + 1;

  // stage map
  localparam int ST_LN    = P_W;
  localparam int ST_RDIV0 = ST_LN + 1;
  localparam int ST_SQI   = ST_RDIV0 + R_W;
  localparam int ST_SQ0   = ST_SQI + 1;
  localparam int ST_MUL   = ST_SQ0 + S_W;
  localparam int ST_SUM   = ST_MUL + 1;
  localparam int N_STAGE  = ST_SUM + 1;

  typedef struct packed {
    logic                   unv;
    logic                   pzero;
    logic                   wlsb;
    logic [COUNT_WIDTH-1:0] v;
    logic [COUNT_WIDTH-1:0] prem;
    logic [P_W-1:0]         pq;
    logic [Y_W-1:0]         y;
    logic [K_W-1:0]         k;
    logic [FRAC_BITS-1:0]   lfrac;
    logic [LN_W-1:0]        rdiv;
    logic [COUNT_WIDTH-1:0] rrem;
    logic [R_W-1:0]         rq;
    logic [SX_W-1:0]        sx;
    logic [SRES_W-1:0]      sres;
    logic [SCORE_W-1:0]     e;
    logic [SCORE_W-1:0]     score;
  } stg_t;

endpackage

>>> rtl/uct_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uct_in_if
// Node beat channel: counts of one tree node and the opponent flag.
// ----------------------------------------------------------------------------
interface uct_in_if;
  logic                            valid;
  logic                            ready;
  logic [uct_pkg::COUNT_WIDTH-1:0] node_wins;
  logic [uct_pkg::COUNT_WIDTH-1:0] node_visits;
  logic [uct_pkg::COUNT_WIDTH-1:0] parent_visits;
  logic                            opponent_view;

  modport source (output valid, node_wins, node_visits, parent_visits, opponent_view,
                  input ready);
  modport sink   (input valid, node_wins, node_visits, parent_visits, opponent_view,
                  output ready);
endinterface

>>> rtl/uct_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uct_out_if
// Score beat channel: saturated score and unvisited flag.
// ----------------------------------------------------------------------------
interface uct_out_if;
  logic                        valid;
  logic                        ready;
  logic [uct_pkg::SCORE_W-1:0] score;
  logic                        unvisited;

  modport source (output valid, score, unvisited, input ready);
  modport sink   (input valid, score, unvisited, output ready);
endinterface

>>> rtl/uct_score_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uct_score_unit
// Pipelined UCB1 score: w/v + c*sqrt(ln(parent)/v) in unsigned Q5.16.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one node per beat (wins, visits, parent visits, opponent
//         flag); out_o returns one score beat per node, in order.
//   cfg_we_i/cfg_wdata_i write the exploration constant c (Q2.14); write it
//   only while no beat is in flight. Reset loads sqrt(2).
// Throughput: one beat per cycle while not stalled (see Stall). Pipeline
//   from input accept to output valid: a 17-step win-rate divider
//   beside 16 log2 squaring stages, one ln multiply, a 21-step divider by
//   visits, a 19-step square root, the c multiply and the final add.
// Stall: the whole pipeline holds while the last stage carries a beat the
//   receiver does not take; in_i.ready drops for that cycle. Bubbles travel
//   with their valid bits and nothing is lost or repeated.
// Reset: clears all valid bits; the pipeline is empty and ready at once.
// Special cases: zero visits gives all-ones score and unvisited=1; parent
//   visits of zero or one give no exploration term; wins clamp to visits;
//   the sum saturates to all ones.
// ----------------------------------------------------------------------------
module uct_score_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [uct_pkg::C_W-1:0] cfg_wdata_i,
  uct_in_if.sink               in_i,
  uct_out_if.source            out_o
);
  import uct_pkg::*;

  `include "uct_score_unit_assert.svh"

  logic [C_W-1:0]   c_q;
  logic [N_STAGE-1:0] vld_q;
  stg_t             st_q [N_STAGE];
  stg_t             st_d [N_STAGE];
  logic             en;

  // advance whenever the last stage is empty or being taken
  assign en         = !vld_q[N_STAGE-1] || out_o.ready;
  assign in_i.ready = en;

  assign out_o.valid     = vld_q[N_STAGE-1];
  assign out_o.score     = st_q[N_STAGE-1].score;
  assign out_o.unvisited = st_q[N_STAGE-1].unv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= C_RESET;
    end else if (cfg_we_i) begin
      c_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N_STAGE-2:0], in_i.valid};
    end
  end

  // Entry stage: clamp wins, flip them for the opponent view, normalize parent visits.
  always_comb begin
    logic [COUNT_WIDTH-1:0] wc;
    logic [K_W-1:0]         kk;
    st_d[0] = '0;
    wc = (in_i.node_wins > in_i.node_visits) ? in_i.node_visits : in_i.node_wins;
    if (in_i.opponent_view) begin
      wc = in_i.node_visits - wc;
    end
    kk = '0;
    for (int i = 0; i < COUNT_WIDTH; i++) begin
      if (in_i.parent_visits[i]) begin
        kk = K_W'(i);
      end
    end
    st_d[0].unv   = (in_i.node_visits == '0);
    st_d[0].pzero = (in_i.parent_visits <= COUNT_WIDTH'(1));
    st_d[0].v     = in_i.node_visits;
    st_d[0].prem  = {1'b0, wc[COUNT_WIDTH-1:1]};
    st_d[0].wlsb  = wc[0];
    st_d[0].k     = kk;
    st_d[0].y     = Y_W'(in_i.parent_visits) << (Y_W'(MANT_FRAC) - Y_W'(kk));
  end

  for (genvar j = 1; j < N_STAGE; j++) begin : g_stage
    always_comb begin
      logic [COUNT_WIDTH:0]     pt;
      logic [2*Y_W-1:0]         sq;
      logic [Y_W:0]             t;
      logic [L2_W-1:0]          l2;
      logic [L2_W+LN2_W-1:0]    lnp;
      logic [COUNT_WIDTH:0]     rt;
      logic [SRES_W-1:0]        sb;
      logic [SRES_W-1:0]        rb;
      logic [C_W+S_W-1:0]       cm;
      logic [SCORE_W:0]         sm;
      st_d[j] = st_q[j-1];
      pt = '0; sq = '0; t = '0; l2 = '0; lnp = '0; rt = '0;
      sb = '0; rb = '0; cm = '0; sm = '0;
      // win-rate divider, one quotient bit per stage
      if (j <= P_W) begin
        pt = {st_q[j-1].prem, (j == 1) ? st_q[j-1].wlsb : 1'b0};
        if (pt >= {1'b0, st_q[j-1].v}) begin
          pt = pt - {1'b0, st_q[j-1].v};
          st_d[j].pq = {st_q[j-1].pq[P_W-2:0], 1'b1};
        end else begin
          st_d[j].pq = {st_q[j-1].pq[P_W-2:0], 1'b0};
        end
        st_d[j].prem = pt[COUNT_WIDTH-1:0];
      end
      // log2 fraction, one squaring per stage
      if (j <= FRAC_BITS) begin
        sq = st_q[j-1].y * st_q[j-1].y;
        t  = sq[MANT_FRAC +: Y_W+1];
        if (t[Y_W]) begin
          st_d[j].y     = t[Y_W:1];
          st_d[j].lfrac = {st_q[j-1].lfrac[FRAC_BITS-2:0], 1'b1};
        end else begin
          st_d[j].y     = t[Y_W-1:0];
          st_d[j].lfrac = {st_q[j-1].lfrac[FRAC_BITS-2:0], 1'b0};
        end
      end
      // natural log and divider setup
      if (j == ST_LN) begin
        l2  = st_q[j-1].pzero ? '0 : {st_q[j-1].k, st_q[j-1].lfrac};
        lnp = l2 * LN2_Q32;
        st_d[j].rdiv = lnp[LN2_W +: LN_W];
        st_d[j].rrem = '0;
        st_d[j].rq   = '0;
      end
      // ln / visits, one quotient bit per stage
      if (j >= ST_RDIV0 && j < ST_RDIV0 + R_W) begin
        rt = {st_q[j-1].rrem, st_q[j-1].rdiv[LN_W-1]};
        st_d[j].rdiv = {st_q[j-1].rdiv[LN_W-2:0], 1'b0};
        if (rt >= {1'b0, st_q[j-1].v}) begin
          rt = rt - {1'b0, st_q[j-1].v};
          st_d[j].rq = {st_q[j-1].rq[R_W-2:0], 1'b1};
        end else begin
          st_d[j].rq = {st_q[j-1].rq[R_W-2:0], 1'b0};
        end
        st_d[j].rrem = rt[COUNT_WIDTH-1:0];
      end
      if (j == ST_SQI) begin
        st_d[j].sx   = {st_q[j-1].rq, {FRAC_BITS{1'b0}}};
        st_d[j].sres = '0;
      end
      // square root, two radicand bits per stage
      if (j >= ST_SQ0 && j < ST_SQ0 + S_W) begin
        sb = SRES_W'(1) << (2 * (S_W - 1 - (j - ST_SQ0)));
        rb = st_q[j-1].sres + sb;
        if ({1'b0, st_q[j-1].sx} >= rb) begin
          st_d[j].sx   = st_q[j-1].sx - rb[SX_W-1:0];
          st_d[j].sres = (st_q[j-1].sres >> 1) + sb;
        end else begin
          st_d[j].sres = st_q[j-1].sres >> 1;
        end
      end
      if (j == ST_MUL) begin
        cm = c_q * st_q[j-1].sres[S_W-1:0];
        st_d[j].e = cm[C_FRAC +: SCORE_W];
      end
      if (j == ST_SUM) begin
        sm = SCORE_W'(st_q[j-1].pq) + st_q[j-1].e;
        if (sm[SCORE_W] || st_q[j-1].unv) begin
          st_d[j].score = '1;
        end else begin
          st_d[j].score = sm[SCORE_W-1:0];
        end
      end
    end
  end

  for (genvar j = 0; j < N_STAGE; j++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[j] <= st_d[j];
      end
    end
  end

  `UCT_ASSERT_NEXT(a_accept_enters, in_i.valid && in_i.ready, vld_q[0], "accepted beat lost at entry")
  `UCT_ASSERT_NEXT(a_stall_holds, out_o.valid && !out_o.ready, $stable(vld_q), "pipeline moved during stall")
  `UCT_ASSERT_SAME(a_rate_bound, vld_q[ST_LN] && !st_q[ST_LN].unv, st_q[ST_LN].pq <= (P_W'(1) << FRAC_BITS), "win rate above one")
  `UCT_ASSERT_SAME(a_unv_max, out_o.valid && out_o.unvisited, out_o.score == '1, "unvisited score not max")

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for uct_score_unit: drives node beats with random
// gaps, back-pressures the score channel, predicts every score in fixed
// point and compares the beats in order. Sweeps the exploration constant.
// ----------------------------------------------------------------------------
module testbench;
  import uct_pkg::*;

  localparam int                     PERIOD_CYC = 70;  // drain margin beyond the pipeline latency
  localparam logic [63:0]            LN2_FIX    = 64'd2977044472;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX    = '1;

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic               unvisited;
  } score_beat_t;

  // Score predictor and in-order store of expected score beats.
  class score_board;
    logic [C_W-1:0] c_weight;
    score_beat_t    pending[$];
    int             errors;

    function new();
      c_weight = C_RESET;
      errors   = 0;
    endfunction

    // log2 of x (x >= 2) in Q.16 by repeated squaring of the mantissa
    function logic [63:0] log2_q(logic [63:0] x);
      int          k;
      logic [63:0] t;
      logic [63:0] y;
      logic [63:0] frac;
      k = 0;
      t = x;
      frac = 0;
      while (t > 1) begin
        t = t >> 1;
        k++;
      end
      y = x << (MANT_FRAC - k);
      for (int i = 0; i < FRAC_BITS; i++) begin
        y = (y * y) >> MANT_FRAC;
        frac = frac << 1;
        if (y >= (64'd2 << MANT_FRAC)) begin
          y = y >> 1;
          frac = frac | 1;
        end
      end
      return (64'(k) << FRAC_BITS) | frac;
    endfunction

    function logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Compute the expected beat of one accepted node.
    function void note_node(logic [COUNT_WIDTH-1:0] wins, logic [COUNT_WIDTH-1:0] visits,
                            logic [COUNT_WIDTH-1:0] parent, logic opp);
      score_beat_t b;
      logic [63:0] w, v, p, ln, r, s, e, sum;
      v = visits;
      w = wins;
      if (v == 0) begin
        b.score = '1;
        b.unvisited = 1'b1;
      end else begin
        if (w > v) w = v;
        if (opp) w = v - w;
        p = (w << FRAC_BITS) / v;
        ln = (parent > 1) ? ((log2_q(64'(parent)) * LN2_FIX) >> 32) : 64'd0;
        r = ln / v;
        s = root_floor(r << FRAC_BITS);
        e = (64'(c_weight) * s) >> C_FRAC;
        sum = p + e;
        if (sum > (64'd1 << SCORE_W) - 1) sum = (64'd1 << SCORE_W) - 1;
        b.score = sum[SCORE_W-1:0];
        b.unvisited = 1'b0;
      end
      pending = {pending, b};
    endfunction

    function void check_beat(logic [SCORE_W-1:0] score, logic unvisited);
      score_beat_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected score beat score=%0d unvisited=%0b", $time, score,
                 unvisited);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (score !== x.score) begin
        $display("%0t: score mismatch expected=%0d actual=%0d", $time, x.score, score);
        errors++;
      end
      if (unvisited !== x.unvisited) begin
        $display("%0t: unvisited mismatch expected=%0b actual=%0b", $time, x.unvisited,
                 unvisited);
        errors++;
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [C_W-1:0] cfg_wdata_i;

  uct_in_if  node_ch ();
  uct_out_if score_ch ();

  uct_score_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (node_ch.sink),
    .out_o       (score_ch.source)
  );

  score_board sb = new();

  bit idle_en;    // random gaps on both channels
  bit hold_req;   // ask the receiver for one long hold-off

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Monitor: sample both handshakes at the edge, check before noting.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (score_ch.valid && score_ch.ready) sb.check_beat(score_ch.score, score_ch.unvisited);
      if (node_ch.valid && node_ch.ready)
        sb.note_node(node_ch.node_wins, node_ch.node_visits, node_ch.parent_visits,
                     node_ch.opponent_view);
    end
  end

  // Receiver: bursts of ready and stall, plus one long hold-off on request.
  initial begin
    score_ch.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        score_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 2) == 0) begin
        score_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        score_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Offer one node beat and hold it until accepted; at random, drop valid for a gap first.
  task automatic send_node(logic [COUNT_WIDTH-1:0] w, logic [COUNT_WIDTH-1:0] v,
                           logic [COUNT_WIDTH-1:0] pv, logic opp);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      node_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    node_ch.valid         <= 1'b1;
    node_ch.node_wins     <= w;
    node_ch.node_visits   <= v;
    node_ch.parent_visits <= pv;
    node_ch.opponent_view <= opp;
    @(posedge clk_i);
    while (!node_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_random_node();
    logic [COUNT_WIDTH-1:0] w, v, pv;
    v  = COUNT_WIDTH'($urandom_range(1, 1000));
    w  = COUNT_WIDTH'($urandom_range(0, v + 5));
    pv = $urandom_range(0, 1) ? COUNT_WIDTH'($urandom_range(0, 5000))
                              : COUNT_WIDTH'($urandom);
    case ($urandom_range(0, 9))
      0: v = '0;
      1: begin
        v  = COUNT_WIDTH'($urandom_range(1, 16));
        w  = COUNT_WIDTH'($urandom_range(0, 20));
        pv = COUNT_WIDTH'($urandom_range(0, 3));
      end
      2, 3: begin
        w  = COUNT_WIDTH'($urandom);
        v  = COUNT_WIDTH'($urandom);
        pv = COUNT_WIDTH'($urandom);
      end
      4: begin
        v = CNT_MAX;
        w = COUNT_WIDTH'($urandom);
      end
      default: ;
    endcase
    send_node(w, v, pv, 1'($urandom_range(0, 1)));
  endtask

  // Drain every expected beat, then let the pipeline settle.
  task automatic drain();
    node_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (PERIOD_CYC) @(posedge clk_i);
  endtask

  task automatic write_weight(logic [C_W-1:0] c);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.c_weight = c;
  endtask

  initial begin
    logic [C_W-1:0] sweep[4];
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_wdata_i           = '0;
    node_ch.valid         = 1'b0;
    node_ch.node_wins     = '0;
    node_ch.node_visits   = '0;
    node_ch.parent_visits = '0;
    node_ch.opponent_view = 1'b0;
    idle_en  = 1'b1;
    hold_req = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, unvisited, tiny parents, clamped wins.
    send_node(0, 0, 0, 0);
    send_node(5, 0, 100, 1);
    send_node(CNT_MAX, CNT_MAX, CNT_MAX, 0);
    send_node(CNT_MAX, CNT_MAX, CNT_MAX, 1);
    send_node(0, 1, CNT_MAX, 0);
    send_node(0, 1, CNT_MAX, 1);
    send_node(1, 1, 0, 0);
    send_node(1, 1, 1, 1);
    send_node(10, 3, 50, 0);
    send_node(10, 3, 50, 1);
    send_node(0, 1, 2, 0);
    send_node(CNT_MAX, 1, CNT_MAX, 1);
    send_node(7, CNT_MAX, 1, 0);
    send_node(123, 456, 789, 1);
    send_node(CNT_MAX, 0, CNT_MAX, 1);

    sweep[0] = '1;
    sweep[1] = '0;
    sweep[2] = C_W'($urandom);
    sweep[3] = C_RESET;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_weight(sweep[ph]);
      if (ph == 1) hold_req = 1'b1;   // fill the pipe against a stalled receiver
      if (ph == 3) idle_en = 1'b0;
      repeat (500) send_random_node();
    end

    drain();
    if (sb.pending.size() != 0) sb.errors++;
    if (sb.errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/uct_pkg.sv
rtl/uct_in_if.sv
rtl/uct_out_if.sv
rtl/uct_score_unit.sv
sim/testbench.sv
